// ----- src/ctu_pkg.sv -----
// ----------------------------------------------------------------------------
// ctu_pkg
// Shared constants, types and helpers of the Clifford tableau update unit.
// ----------------------------------------------------------------------------
package ctu_pkg;

  localparam int NumQubits = 16;
  localparam int NumRows   = 2 * NumQubits;
  localparam int RowW      = 2 * NumQubits + 1;
  localparam int PhasePos  = 2 * NumQubits;
  localparam int RowAddrW  = $clog2(NumRows);
  localparam int CntW      = $clog2(NumRows + 1);

  localparam int FuncW     = 4;
  localparam int QubitW    = 4;
  localparam int RowIdxW   = 5;
  localparam int OutRowW   = 33;
  localparam int OutPhaseW = 32;

  localparam logic [FuncW-1:0] FuncX      = 4'd0;
  localparam logic [FuncW-1:0] FuncY      = 4'd1;
  localparam logic [FuncW-1:0] FuncZ      = 4'd2;
  localparam logic [FuncW-1:0] FuncH      = 4'd3;
  localparam logic [FuncW-1:0] FuncS      = 4'd4;
  localparam logic [FuncW-1:0] FuncSdg    = 4'd5;
  localparam logic [FuncW-1:0] FuncCx     = 4'd6;
  localparam logic [FuncW-1:0] FuncRowsum = 4'd7;
  localparam logic [FuncW-1:0] FuncReinit = 4'd8;
  localparam logic [FuncW-1:0] FuncRead   = 4'd9;

  typedef logic [RowW-1:0] row_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [QubitW-1:0] qa;
    logic [QubitW-1:0] qb;
  } op_t;

  // Identity tableau row: row r has bit r set and phase zero.
  function automatic row_t identity_row(input logic [RowAddrW-1:0] addr);
    row_t r;
    r       = '0;
    r[addr] = 1'b1;
    return r;
  endfunction

endpackage

// ----- src/clifford_tableau_update.sv -----
// ----------------------------------------------------------------------------
// clifford_tableau_update
// Stabilizer tableau of 2N rows held in a RAM, updated by Clifford gates,
// rowsum, re-init and row reads.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | beat
//  ---------+-----------------------------------------------+-------------------
//  command  | start, busy, in_func, in_qubit_a/b, in_row_a/b | start && !busy
//  result   | out_valid, out_row_bits, out_phase_bits,       | out_valid, 1 cycle
//           | out_error                                     |
//
// A gate sweeps all 2N rows through the row RAM, one read and one write-back a
// cycle. Rowsum reads row a, then row b, and writes the sum back to row a; a
// row read reads the RAM and returns it; re-init and rejected beats go straight
// to the result strobe. Busy is high from the accepted beat until the result
// strobe, which the receiver cannot stall. Reset and re-init restore the
// identity at once through per-row valid bits; the RAM itself is never cleared.
// ----------------------------------------------------------------------------
module clifford_tableau_update import ctu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FuncW-1:0]     in_func,
  input  logic [QubitW-1:0]    in_qubit_a,
  input  logic [QubitW-1:0]    in_qubit_b,
  input  logic [RowIdxW-1:0]   in_row_a,
  input  logic [RowIdxW-1:0]   in_row_b,
  output logic                 out_valid,
  output logic [OutRowW-1:0]   out_row_bits,
  output logic [OutPhaseW-1:0] out_phase_bits,
  output logic                 out_error
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SWEEP   = 3'd1;
  localparam logic [2:0] S_RS_H    = 3'd2;
  localparam logic [2:0] S_RS_I    = 3'd3;
  localparam logic [2:0] S_RS_WR   = 3'd4;
  localparam logic [2:0] S_RD      = 3'd5;
  localparam logic [2:0] S_RD_WAIT = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  op_t                  op_r, op_nxt;
  logic [RowAddrW-1:0]  ra_r, ra_nxt;
  logic [RowAddrW-1:0]  rb_r, rb_nxt;
  row_t                 hold_r, hold_nxt;
  logic [NumRows-1:0]   valid_r, valid_nxt;
  logic [NumRows-1:0]   phase_r, phase_nxt;
  logic                 err_r, err_nxt;
  logic [OutRowW-1:0]   out_row_r, out_row_nxt;
  logic [OutPhaseW-1:0] out_phase_r, out_phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 data_vld_r;
  logic                 rd_valid_q_r;
  logic [RowAddrW-1:0]  rd_addr_q_r;

  logic                 ram_we;
  logic [RowAddrW-1:0]  ram_waddr;
  logic                 ram_re;
  logic [RowAddrW-1:0]  ram_raddr;
  row_t                 ram_q;
  row_t                 rdata;
  row_t                 alu_in;
  row_t                 alu_out;

  ctu_ram #(
    .Width (RowW),
    .Depth (NumRows)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (alu_out),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // A row never written since reset or re-init reads as its identity row.
  assign rdata  = rd_valid_q_r ? ram_q : identity_row(rd_addr_q_r);
  assign alu_in = (state_r == S_RS_WR) ? hold_r : rdata;

  ctu_row_alu u_alu (
    .op      (op_r),
    .row_in  (alu_in),
    .src_row (rdata),
    .row_out (alu_out)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    hold_nxt      = hold_r;
    valid_nxt     = valid_r;
    phase_nxt     = phase_r;
    err_nxt       = err_r;
    out_row_nxt   = out_row_r;
    out_phase_nxt = out_phase_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = rd_addr_q_r;
    ram_re        = 1'b0;
    ram_raddr     = ra_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = '{func: in_func, qa: in_qubit_a, qb: in_qubit_b};
          ra_nxt      = RowAddrW'(in_row_a);
          rb_nxt      = RowAddrW'(in_row_b);
          cnt_nxt     = '0;
          err_nxt     = 1'b0;
          out_row_nxt = '0;
          state_nxt   = S_DONE;
          case (in_func) inside
            [FuncX:FuncSdg]: begin
              if (int'(in_qubit_a) >= NumQubits) err_nxt = 1'b1;
              else state_nxt = S_SWEEP;
            end
            FuncCx: begin
              if (int'(in_qubit_a) >= NumQubits || int'(in_qubit_b) >= NumQubits
                  || in_qubit_a == in_qubit_b) err_nxt = 1'b1;
              else state_nxt = S_SWEEP;
            end
            FuncRowsum: begin
              if (int'(in_row_a) >= NumRows || int'(in_row_b) >= NumRows) err_nxt = 1'b1;
              else state_nxt = S_RS_H;
            end
            FuncReinit: begin
              valid_nxt = '0;
              phase_nxt = '0;
            end
            FuncRead: begin
              if (int'(in_row_a) >= NumRows) err_nxt = 1'b1;
              else state_nxt = S_RD;
            end
            default: err_nxt = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        // Read row k while row k-1, read the cycle before, is written back.
        if (cnt_r < CntW'(NumRows)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[RowAddrW-1:0];
          cnt_nxt   = cnt_r + CntW'(1);
        end
        if (data_vld_r) begin
          ram_we                 = 1'b1;
          valid_nxt[rd_addr_q_r] = 1'b1;
          phase_nxt[rd_addr_q_r] = alu_out[PhasePos];
          if (rd_addr_q_r == RowAddrW'(NumRows - 1)) state_nxt = S_DONE;
        end
      end
      S_RS_H: begin
        ram_re    = 1'b1;
        ram_raddr = ra_r;
        state_nxt = S_RS_I;
      end
      S_RS_I: begin
        ram_re    = 1'b1;
        ram_raddr = rb_r;
        hold_nxt  = rdata;
        state_nxt = S_RS_WR;
      end
      S_RS_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = ra_r;
        valid_nxt[ra_r] = 1'b1;
        phase_nxt[ra_r] = alu_out[PhasePos];
        out_row_nxt     = OutRowW'(alu_out);
        state_nxt       = S_DONE;
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ra_r;
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        out_row_nxt = OutRowW'(rdata);
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_phase_nxt = OutPhaseW'(phase_r);
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      phase_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      data_vld_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      data_vld_r  <= ram_re;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    hold_r      <= hold_nxt;
    out_row_r   <= out_row_nxt;
    out_phase_r <= out_phase_nxt;
    if (ram_re) begin
      rd_addr_q_r  <= ram_raddr;
      rd_valid_q_r <= valid_r[ram_raddr];
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_row_bits   = out_row_r;
  assign out_phase_bits = out_phase_r;
  assign out_error      = err_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SWEEP || state_r == S_RS_WR))
    else $error("row RAM written outside an update");

  a_error_no_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> (out_row_r == '0))
    else $error("rejected beat returned row data");

endmodule

// ----- src/ctu_ram.sv -----
// ----------------------------------------------------------------------------
// ctu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ctu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/ctu_row_alu.sv -----
// ----------------------------------------------------------------------------
// ctu_row_alu
// Row update logic: Pauli, H, S, Sdg and CX column rules on one row, and the
// rowsum of a source row into a destination row.
// ----------------------------------------------------------------------------
module ctu_row_alu import ctu_pkg::*; (
  input  op_t  op,
  input  row_t row_in,
  input  row_t src_row,
  output row_t row_out
);

  // Phase exponent contribution, mod 4, of source (x1,z1) times destination (x2,z2).
  function automatic logic [1:0] g_mod4(input logic x1, input logic z1,
                                         input logic x2, input logic z2);
    logic [1:0] g;
    g = 2'd0;
    if (x1 && z1) begin
      g = {1'b0, z2} - {1'b0, x2};
    end else if (x1) begin
      g = z2 ? (x2 ? 2'd1 : 2'd3) : 2'd0;
    end else if (z1) begin
      g = x2 ? (z2 ? 2'd3 : 2'd1) : 2'd0;
    end
    return g;
  endfunction

  logic [1:0] g_lvl [2*NumQubits-1];
  logic [1:0] acc;
  row_t       gate_row;
  row_t       sum_row;

  // Rowsum: the g terms are added in a balanced tree of 2-bit adders.
  always_comb begin
    for (int j = 0; j < NumQubits; j++) begin
      g_lvl[j] = g_mod4(src_row[j], src_row[NumQubits+j],
                        row_in[j], row_in[NumQubits+j]);
    end
    for (int j = NumQubits; j < 2 * NumQubits - 1; j++) begin
      g_lvl[j] = g_lvl[2*(j-NumQubits)] + g_lvl[2*(j-NumQubits)+1];
    end
    acc = g_lvl[2*NumQubits-2] + {row_in[PhasePos], 1'b0} + {src_row[PhasePos], 1'b0};
    sum_row           = row_in ^ src_row;
    sum_row[PhasePos] = (acc != 2'd0);
  end

  always_comb begin
    logic x;
    logic z;
    logic xc;
    logic zc;
    logic xt;
    logic zt;
    x  = row_in[op.qa];
    z  = row_in[NumQubits + int'(op.qa)];
    xc = x;
    zc = z;
    xt = row_in[op.qb];
    zt = row_in[NumQubits + int'(op.qb)];
    gate_row = row_in;
    case (op.func)
      FuncX: gate_row[PhasePos] = row_in[PhasePos] ^ z;
      FuncY: gate_row[PhasePos] = row_in[PhasePos] ^ x ^ z;
      FuncZ: gate_row[PhasePos] = row_in[PhasePos] ^ x;
      FuncH: begin
        gate_row[op.qa]                   = z;
        gate_row[NumQubits + int'(op.qa)] = x;
        gate_row[PhasePos]                = row_in[PhasePos] ^ (x & z);
      end
      FuncS: begin
        gate_row[NumQubits + int'(op.qa)] = z ^ x;
        gate_row[PhasePos]                = row_in[PhasePos] ^ (x & z);
      end
      FuncSdg: begin
        gate_row[NumQubits + int'(op.qa)] = z ^ x;
        gate_row[PhasePos]                = row_in[PhasePos] ^ (x & ~z);
      end
      FuncCx: begin
        gate_row[op.qb]                   = xt ^ xc;
        gate_row[NumQubits + int'(op.qa)] = zc ^ zt;
        gate_row[PhasePos]                = row_in[PhasePos] ^ (xc & zt & ~(xt ^ zc));
      end
      default: gate_row = row_in;
    endcase
  end

  assign row_out = (op.func == FuncRowsum) ? sum_row : gate_row;

endmodule
